// ===== rtl/core/ope_pkg.sv =====
package ope_pkg;

    localparam int CODE_BITS = 25;
    localparam int BIT_IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BURSTS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_GAP   = 3'd6;

    localparam logic [11:0] RST_BIT_PERIOD = 12'd720;
    localparam logic [11:0] RST_SHORT_GAP  = 12'd125;
    localparam logic [11:0] RST_LONG_GAP   = 12'd471;
    localparam logic [15:0] RST_FRAME_GAP  = 16'd5364;
    localparam logic [3:0]  RST_FRAMES     = 4'd10;
    localparam logic [2:0]  RST_BURSTS     = 3'd3;
    localparam logic [19:0] RST_BURST_GAP  = 20'd500000;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [CODE_BITS-1:0] command;
    } t_in_item;

    typedef struct packed {
        logic line;
        logic busy_res;
        logic done_res;
    } t_out_item;

    typedef struct packed {
        logic [11:0] bit_period;
        logic [11:0] short_gap;
        logic [11:0] long_gap;
        logic [15:0] frame_gap;
        logic [3:0]  frames_per_burst;
        logic [2:0]  burst_count;
        logic [19:0] burst_gap;
    } t_cfg;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_HIGH = 5'b00010,
        PH_LOW  = 5'b00100,
        PH_FGAP = 5'b01000,
        PH_BGAP = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [19:0]          time_left;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic [3:0]           frame_idx;
        logic [2:0]           burst_idx;
        logic [CODE_BITS-1:0] code;
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic settling;
    } t_seq_status;

    function automatic logic [11:0] gap_of(logic [CODE_BITS-1:0] code,
                                           logic [BIT_IDX_W-1:0] idx, t_cfg c);
        logic [BIT_IDX_W-1:0] pos;
        pos = BIT_IDX_W'(CODE_BITS - 1) - idx;
        return code[pos] ? c.short_gap : c.long_gap;
    endfunction

    function automatic logic [19:0] high_time(logic [11:0] bp, logic [11:0] g);
        return (bp > g) ? 20'(bp - g) : 20'd0;
    endfunction

endpackage

// ===== rtl/core/ook_remote_pulse_encoder.sv =====
// Pulse-width encoder for an on-off keyed remote plug transmitter.
// Input channel (i_in_valid/o_in_ready/i_in_item): each item is either a
// one microsecond tick (func 0) or a start (func 1) carrying the 25-bit
// command. A start while a sequence runs is ignored but still answered.
// Output channel (o_out_valid/i_out_ready/o_out_item): exactly one item per
// input item, in order: line level, busy flag and done flag.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_idx;
// write only while idle. Unknown indexes are dropped.
// An accepted item passes the input register, then the skid output
// register. Throughput: one item per cycle while the output is not stalled.
// An item that crosses several zero-length phases in a row holds the input
// register until the last of them is resolved, since the sequencer resolves
// one phase per cycle; with nonzero gaps shorter than the bit period and
// nonzero frame and burst gaps this never happens.
// Reset (i_rst_n low, synchronous): idle, all registers at default timing.
// Output stall: a skid register takes one more item, then o_in_ready drops.
module ook_remote_pulse_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ope_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ope_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ope_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ope_pkg::t_out_item              o_out_item
);

    ope_pkg::t_cfg        cfg;
    ope_pkg::t_out_item   res;
    ope_pkg::t_seq_status status;
    logic                 res_valid;
    logic                 res_ready;

    ope_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ope_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_status    (status)
    );

    ope_out_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (res_valid),
        .o_in_ready  (res_ready),
        .i_in_item   (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.line |-> o_out_item.busy_res)
        else $error("line high without busy");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |-> o_out_item.busy_res)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_ready && res.done_res |=> !status.busy)
        else $error("sequencer still busy after done");

    a_settle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.settling |-> status.busy)
        else $error("phase skip outside a running sequence");

endmodule

// ===== rtl/core/ope_cfg_regs.sv =====
module ope_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ope_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ope_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output ope_pkg::t_cfg                   o_cfg
);

    ope_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period       <= ope_pkg::RST_BIT_PERIOD;
            r_cfg.short_gap        <= ope_pkg::RST_SHORT_GAP;
            r_cfg.long_gap         <= ope_pkg::RST_LONG_GAP;
            r_cfg.frame_gap        <= ope_pkg::RST_FRAME_GAP;
            r_cfg.frames_per_burst <= ope_pkg::RST_FRAMES;
            r_cfg.burst_count      <= ope_pkg::RST_BURSTS;
            r_cfg.burst_gap        <= ope_pkg::RST_BURST_GAP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                ope_pkg::CFG_BIT_PERIOD: r_cfg.bit_period       <= i_cfg_wdata[11:0];
                ope_pkg::CFG_SHORT_GAP:  r_cfg.short_gap        <= i_cfg_wdata[11:0];
                ope_pkg::CFG_LONG_GAP:   r_cfg.long_gap         <= i_cfg_wdata[11:0];
                ope_pkg::CFG_FRAME_GAP:  r_cfg.frame_gap        <= i_cfg_wdata[15:0];
                ope_pkg::CFG_FRAMES:     r_cfg.frames_per_burst <= i_cfg_wdata[3:0];
                ope_pkg::CFG_BURSTS:     r_cfg.burst_count      <= i_cfg_wdata[2:0];
                ope_pkg::CFG_BURST_GAP:  r_cfg.burst_gap        <= i_cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/ope_seq.sv =====
module ope_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ope_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ope_pkg::t_in_item     i_in_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output ope_pkg::t_out_item    o_res,
    output ope_pkg::t_seq_status  o_status
);

    ope_pkg::t_in_item   r_in;
    logic                r_in_valid;
    ope_pkg::t_seq_state r_st;
    ope_pkg::t_seq_state n_st;
    ope_pkg::t_seq_state w_st;
    logic                r_settling;
    logic                r_hold_line;

    logic finish;
    logic fire;
    logic advance;
    logic is_start;
    logic line_out;
    logic busy_out;
    logic done_out;

    function automatic logic final_bgap(ope_pkg::t_seq_state s, ope_pkg::t_cfg c);
        logic [3:0] bursts;
        bursts = (c.burst_count == 3'd0) ? 4'd1 : {1'b0, c.burst_count};
        return (s.phase == ope_pkg::PH_BGAP) && (({1'b0, s.burst_idx} + 4'd1) >= bursts);
    endfunction

    function automatic ope_pkg::t_seq_state next_phase(ope_pkg::t_seq_state s,
                                                       ope_pkg::t_cfg c);
        ope_pkg::t_seq_state   t;
        logic [4:0]            frames;
        logic [ope_pkg::BIT_IDX_W-1:0] zero_idx;
        t        = s;
        zero_idx = '0;
        frames   = (c.frames_per_burst == 4'd0) ? 5'd1 : {1'b0, c.frames_per_burst};
        case (s.phase)
            ope_pkg::PH_HIGH: begin
                t.phase     = ope_pkg::PH_LOW;
                t.time_left = 20'(ope_pkg::gap_of(s.code, s.bit_idx, c));
            end
            ope_pkg::PH_LOW: begin
                if (s.bit_idx == ope_pkg::BIT_IDX_W'(ope_pkg::CODE_BITS - 1)) begin
                    t.phase     = ope_pkg::PH_FGAP;
                    t.time_left = 20'(c.frame_gap);
                end else begin
                    t.bit_idx   = s.bit_idx + 1'b1;
                    t.phase     = ope_pkg::PH_HIGH;
                    t.time_left = ope_pkg::high_time(c.bit_period,
                                      ope_pkg::gap_of(s.code, t.bit_idx, c));
                end
            end
            ope_pkg::PH_FGAP: begin
                if (({1'b0, s.frame_idx} + 5'd1) < frames) begin
                    t.frame_idx = s.frame_idx + 4'd1;
                    t.bit_idx   = zero_idx;
                    t.phase     = ope_pkg::PH_HIGH;
                    t.time_left = ope_pkg::high_time(c.bit_period,
                                      ope_pkg::gap_of(s.code, zero_idx, c));
                end else begin
                    t.frame_idx = s.frame_idx + 4'd1;
                    t.phase     = ope_pkg::PH_BGAP;
                    t.time_left = c.burst_gap;
                end
            end
            ope_pkg::PH_BGAP: begin
                t.burst_idx = s.burst_idx + 3'd1;
                t.frame_idx = 4'd0;
                t.bit_idx   = zero_idx;
                t.phase     = ope_pkg::PH_HIGH;
                t.time_left = ope_pkg::high_time(c.bit_period,
                                  ope_pkg::gap_of(s.code, zero_idx, c));
            end
            default: begin
                t.phase     = ope_pkg::PH_IDLE;
                t.time_left = 20'd0;
            end
        endcase
        return t;
    endfunction

    always_comb begin
        is_start = (r_in.func == ope_pkg::FUNC_START);
        w_st     = r_st;
        if (!r_settling) begin
            if (is_start) begin
                if (r_st.phase == ope_pkg::PH_IDLE) begin
                    w_st.code      = r_in.command;
                    w_st.bit_idx   = '0;
                    w_st.frame_idx = 4'd0;
                    w_st.burst_idx = 3'd0;
                    w_st.phase     = ope_pkg::PH_HIGH;
                    w_st.time_left = ope_pkg::high_time(i_cfg.bit_period,
                                         ope_pkg::gap_of(r_in.command, '0, i_cfg));
                end
            end else if (r_st.phase != ope_pkg::PH_IDLE && r_st.time_left != 20'd0) begin
                w_st.time_left = r_st.time_left - 20'd1;
            end
        end

        // one zero-length phase resolved per cycle while an item is in the input register
        n_st     = w_st;
        finish   = 1'b1;
        done_out = 1'b0;
        if (w_st.phase != ope_pkg::PH_IDLE && w_st.time_left == 20'd0) begin
            if (final_bgap(w_st, i_cfg)) begin
                if (!is_start) begin
                    n_st.phase     = ope_pkg::PH_IDLE;
                    n_st.bit_idx   = '0;
                    n_st.frame_idx = 4'd0;
                    n_st.burst_idx = 3'd0;
                    done_out       = 1'b1;
                end
            end else begin
                n_st   = next_phase(w_st, i_cfg);
                finish = (n_st.time_left != 20'd0) || (n_st.phase == ope_pkg::PH_IDLE);
            end
        end

        if (is_start) begin
            line_out = (n_st.phase == ope_pkg::PH_HIGH);
            busy_out = 1'b1;
        end else if (r_settling) begin
            line_out = r_hold_line;
            busy_out = 1'b1;
        end else begin
            line_out = (r_st.phase == ope_pkg::PH_HIGH);
            busy_out = (r_st.phase != ope_pkg::PH_IDLE);
        end
    end

    assign fire        = r_in_valid && finish && i_res_ready;
    assign advance     = r_in_valid && (!finish || i_res_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_res_valid = r_in_valid && finish;
    assign o_res       = '{line: line_out, busy_res: busy_out, done_res: done_out};
    assign o_status    = '{busy: (r_st.phase != ope_pkg::PH_IDLE), settling: r_settling};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_settling     <= 1'b0;
            r_st.phase     <= ope_pkg::PH_IDLE;
            r_st.time_left <= 20'd0;
            r_st.bit_idx   <= '0;
            r_st.frame_idx <= 4'd0;
            r_st.burst_idx <= 3'd0;
            r_st.code      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_st       <= n_st;
                r_settling <= !finish;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance && !finish) begin
            r_hold_line <= line_out;
        end
    end

endmodule

// ===== rtl/core/ope_out_skid.sv =====
module ope_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ope_pkg::t_out_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ope_pkg::t_out_item o_out_item
);

    logic               r_out_valid;
    logic               r_skid_valid;
    ope_pkg::t_out_item r_out;
    ope_pkg::t_out_item r_skid;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (i_in_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (i_in_valid && !r_skid_valid) begin
                r_skid <= i_in_item;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (i_in_valid) begin
            r_out <= i_in_item;
        end
    end

endmodule
